// ===== hdl/scfp_pkg.sv =====
// Shared types and constants for the serial command frame parser.
package scfp_pkg;

    localparam logic [7:0]  START_BYTE    = 8'hFF;
    localparam logic [7:0]  END_BYTE      = 8'hFE;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    localparam int unsigned PADDR_W = 2;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = 2'd0;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_RECEIVED = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_DISCARD  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        HP_IDLE    = 2'd0,
        HP_COMMAND = 2'd1,
        HP_LENGTH  = 2'd2,
        HP_BODY    = 2'd3
    } header_pos_t;

    typedef struct packed {
        header_pos_t header_position;
        logic [7:0]  bytes_left;
        logic [7:0]  frame_command;
        logic [7:0]  frame_length;
        logic [7:0]  body_position;
        logic [15:0] elapsed_ms;
    } parse_state_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [7:0] body_length;
        logic       body_valid;
        logic [7:0] body_index;
        logic [7:0] body_byte;
    } result_t;

endpackage

// ===== hdl/scfp_if.sv =====
// Valid/ready channel interfaces for parser input and result items.
interface scfp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface scfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] command;
    logic [7:0] body_length;
    logic       body_valid;
    logic [7:0] body_index;
    logic [7:0] body_byte;

    modport source (output valid, output status, output command, output body_length,
                    output body_valid, output body_index, output body_byte, input ready);
    modport sink   (input valid, input status, input command, input body_length,
                    input body_valid, input body_index, input body_byte, output ready);
endinterface

// ===== hdl/scfp_step.sv =====
// Next-state and result logic for one received byte or millisecond tick.
module scfp_step (
    input  scfp_pkg::parse_state_t state,
    input  logic                   mode,
    input  logic [7:0]             rx_byte,
    input  logic [15:0]            timeout_ms,
    output scfp_pkg::parse_state_t state_next,
    output scfp_pkg::result_t      result
);

    scfp_pkg::parse_state_t upd;
    logic [15:0]            elapsed_inc;
    logic                   restart_all;
    logic                   restart_parser;

    assign elapsed_inc = (state.elapsed_ms != scfp_pkg::ELAPSED_MAX)
                       ? state.elapsed_ms + 16'd1 : state.elapsed_ms;

    always_comb
    begin
        upd               = state;
        restart_all       = 1'b0;
        restart_parser    = 1'b0;
        result.status     = scfp_pkg::ST_CONTINUE;
        result.body_valid = 1'b0;
        result.body_index = 8'd0;
        result.body_byte  = 8'd0;

        if (mode)
        begin
            upd.elapsed_ms = elapsed_inc;
            if (elapsed_inc > timeout_ms)
            begin
                result.status = scfp_pkg::ST_TIMEOUT;
                restart_all   = 1'b1;
            end
        end
        else if (state.header_position == scfp_pkg::HP_IDLE && rx_byte == scfp_pkg::START_BYTE)
        begin
            upd.header_position = scfp_pkg::HP_COMMAND;
        end
        else if (state.header_position == scfp_pkg::HP_COMMAND)
        begin
            upd.frame_command   = rx_byte;
            upd.header_position = scfp_pkg::HP_LENGTH;
        end
        else if (state.header_position == scfp_pkg::HP_LENGTH)
        begin
            upd.frame_length    = rx_byte;
            upd.bytes_left      = rx_byte;
            upd.body_position   = 8'd0;
            upd.header_position = scfp_pkg::HP_BODY;
        end
        else if (state.header_position == scfp_pkg::HP_BODY && state.bytes_left != 8'd0)
        begin
            result.body_valid = 1'b1;
            result.body_index = state.body_position;
            result.body_byte  = rx_byte;
            upd.body_position = state.body_position + 8'd1;
            upd.bytes_left    = state.bytes_left - 8'd1;
        end
        else if (state.header_position == scfp_pkg::HP_BODY && rx_byte == scfp_pkg::END_BYTE)
        begin
            result.status = scfp_pkg::ST_RECEIVED;
            restart_all   = 1'b1;
        end
        else if (state.elapsed_ms > timeout_ms)
        begin
            result.status = scfp_pkg::ST_TIMEOUT;
            restart_all   = 1'b1;
        end
        else
        begin
            result.status  = scfp_pkg::ST_DISCARD;
            restart_parser = 1'b1;
        end

        // reported frame fields are taken before any restart
        result.command     = upd.frame_command;
        result.body_length = upd.frame_length;

        state_next = upd;
        if (restart_all || restart_parser)
        begin
            state_next.header_position = scfp_pkg::HP_IDLE;
            state_next.bytes_left      = 8'd0;
            state_next.frame_command   = 8'd0;
            state_next.frame_length    = 8'd0;
            state_next.body_position   = 8'd0;
        end
        if (restart_all)
        begin
            state_next.elapsed_ms = 16'd0;
        end
    end

endmodule

// ===== hdl/serial_command_frame_parser_unit.sv =====
// Top level of the serial command frame parser: state, config register, result skid.
//
//  channel  direction  accepted when             payload
//  in_ch    sink       valid && ready            mode, rx_byte
//  out_ch   source     valid && ready            status, command, body_length, body_*
//  apb      slave      psel && penable && pwrite  timeout_ms at byte address 0
//
// One item per cycle while in_ch.ready is high: the parser state is read and written in the
// cycle an item is accepted, and, unless the output is stalled, its result enters the output
// register at that same edge, offered next cycle. A second result register takes an item
// arriving while the output is stalled; in_ch.ready drops only while that register is full.
// Reset clears the parser, the timer and both result valid flags; timeout_ms returns to 2000.
module serial_command_frame_parser_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    scfp_in_if.sink                        in_ch,
    scfp_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [scfp_pkg::PADDR_W-1:0]   paddr,
    input  logic [scfp_pkg::PDATA_W-1:0]   pwdata,
    output logic [scfp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    scfp_pkg::parse_state_t state_reg, state_next;
    scfp_pkg::result_t      result;
    scfp_pkg::result_t      out_reg, skid_reg;
    logic                   out_valid_reg, skid_valid_reg;
    logic [15:0]            timeout_reg;
    logic                   in_fire, out_fire;

    assign pready = 1'b1;
    assign prdata = (paddr == scfp_pkg::ADDR_TIMEOUT)
                  ? {{(scfp_pkg::PDATA_W-16){1'b0}}, timeout_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= scfp_pkg::TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && paddr == scfp_pkg::ADDR_TIMEOUT)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && !skid_valid_reg;
    assign out_fire    = out_valid_reg && out_ch.ready;

    scfp_step u_step (
        .state      (state_reg),
        .mode       (in_ch.mode),
        .rx_byte    (in_ch.rx_byte),
        .timeout_ms (timeout_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{header_position: scfp_pkg::HP_IDLE, default: '0};
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_reg.status;
    assign out_ch.command     = out_reg.command;
    assign out_ch.body_length = out_reg.body_length;
    assign out_ch.body_valid  = out_reg.body_valid;
    assign out_ch.body_index  = out_reg.body_index;
    assign out_ch.body_byte   = out_reg.body_byte;

endmodule

// ===== hdl/scfp_checker.sv =====
// Port-level checks on the frame parser, bound to the top level.
module scfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       body_valid,
    input logic [7:0] body_index,
    input logic [7:0] body_byte
);

    // a stalled result must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(body_valid)
                                    && $stable(body_index) && $stable(body_byte))
        else $error("result changed while stalled");

    // a body byte is only ever delivered with a continue status
    a_body_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_valid |-> status == scfp_pkg::ST_CONTINUE)
        else $error("body byte carried with a terminal status");

    // no body byte: index and value read as zero
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !body_valid |-> body_index == 8'd0 && body_byte == 8'd0)
        else $error("body fields set without a body byte");

    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !out_valid)
        else $error("result offered straight after reset");

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .body_valid (out_ch.body_valid),
    .body_index (out_ch.body_index),
    .body_byte  (out_ch.body_byte)
);
